// ===== sv/gvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared codes, constants and stage types of the galvanostatic voltage
// controller core.
// ----------------------------------------------------------------------------
package gvc_pkg;

  // Operation codes carried by the opcode field
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOOP_GAIN        = 3'd0;
  localparam logic [2:0] CFG_MAX_VOLTAGE_STEP = 3'd1;
  localparam logic [2:0] CFG_MIN_VOLTAGE      = 3'd2;
  localparam logic [2:0] CFG_MAX_VOLTAGE      = 3'd3;
  localparam logic [2:0] CFG_CURRENT_TOL      = 3'd4;
  localparam logic [2:0] CFG_VOLTAGE_TOL      = 3'd5;
  localparam logic [2:0] CFG_STABLE_SAMPLES   = 3'd6;
  localparam logic [2:0] CFG_HOLD_DURATION    = 3'd7;

  // Smallest current scale used by the relative tests, Q16.16 (100.0)
  localparam int unsigned CURRENT_SCALE_FLOOR = 6553600;
  // Relative current change allowed between samples, Q0.16 (0.02)
  localparam int unsigned STABILITY_TOLERANCE = 1311;

  // Item held in the read stage
  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         tbl_index;
    logic signed [31:0] meas;
    logic signed [31:0] applied;
    logic signed [31:0] ext;
    logic [31:0]        now;
  } gvc_s1_t;

  // Item held in the update stage: products and differences of one sample
  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         tbl_index;
    logic signed [31:0] meas;
    logic signed [31:0] applied;
    logic [31:0]        now;
    logic signed [31:0] target;
    logic signed [31:0] err;
    logic [32:0]        diff_mag;
    logic [39:0]        step_mag;
    logic [47:0]        tol_scale;
    logic [47:0]        stab_scale;
  } gvc_s2_t;

endpackage

// ===== sv/gvc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvc_ram
// Generic single-write, single-read RAM with registered read data. A read
// at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module gvc_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/galvanostatic_voltage_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// galvanostatic_voltage_controller_core
// Proportional voltage controller holding a current density on target, with
// step and window clamps, stability tracking and a table-driven target sweep.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | beat contents
//  --------+--------------------+---------------------------------------------
//  cfg     | cfg_valid/ready    | cfg_index, cfg_data (register write)
//  in      | in_valid/in_stall  | opcode, currents, voltage, ticks, table entry
//  out     | out_valid/out_stall| voltage command, error, flags, sweep status
//
//  One beat per cycle while no stall or target hazard holds the flow; an input
//  beat passes table read, multiply and state update into the output register.
//  A sample behind a table load, a table clear or a target advance waits in
//  the read stage until that item retires, so it reads the updated table entry.
//  Synchronous active-high reset; no clearing pass (table is undefined
//  until loaded). Output stall holds the output register and backs up the
//  pipeline; the input keeps flowing while inner stages have room.
// ----------------------------------------------------------------------------
module galvanostatic_voltage_controller_core
  import gvc_pkg::*;
#(
  parameter int MAX_TARGETS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] measured_current,
  input  logic signed [31:0] applied_voltage,
  input  logic signed [31:0] external_target,
  input  logic [31:0]        now_ticks,
  input  logic [3:0]         table_index,
  input  logic signed [31:0] table_value,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_voltage,
  output logic               apply_voltage,
  output logic signed [31:0] current_error,
  output logic               step_clipped,
  output logic               voltage_clipped,
  output logic               voltage_at_limit,
  output logic [7:0]         stable_count,
  output logic               point_accepted,
  output logic               sweep_complete,
  output logic [3:0]         active_index,
  output logic signed [31:0] active_target
);

  localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]        loop_gain;
  logic [30:0]        max_voltage_step;
  logic signed [31:0] min_voltage;
  logic signed [31:0] max_voltage;
  logic [15:0]        current_tolerance;
  logic [30:0]        voltage_tolerance;
  logic [7:0]         required_stable_samples;
  logic [31:0]        hold_duration;

  assign cfg_ready = 1'b1;

  // Take a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_gain               <= 32'd0;
      max_voltage_step        <= 31'h7FFF_FFFF;
      min_voltage             <= 32'sh8000_0000;
      max_voltage             <= 32'sh7FFF_FFFF;
      current_tolerance       <= 16'd3277;
      voltage_tolerance       <= 31'd328;
      required_stable_samples <= 8'd5;
      hold_duration           <= 32'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOOP_GAIN:        loop_gain               <= cfg_data;
        CFG_MAX_VOLTAGE_STEP: max_voltage_step        <= cfg_data[30:0];
        CFG_MIN_VOLTAGE:      min_voltage             <= cfg_data;
        CFG_MAX_VOLTAGE:      max_voltage             <= cfg_data;
        CFG_CURRENT_TOL:      current_tolerance       <= cfg_data[15:0];
        CFG_VOLTAGE_TOL:      voltage_tolerance       <= cfg_data[30:0];
        CFG_STABLE_SAMPLES:   required_stable_samples <= cfg_data[7:0];
        CFG_HOLD_DURATION:    hold_duration           <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [4:0]         target_count,     target_count_next;
  logic               sweep_mode,       sweep_mode_next;
  logic [3:0]         target_pointer,   target_pointer_next;
  logic [7:0]         stable_counter,   stable_counter_next;
  logic [31:0]        hold_start,       hold_start_next;
  logic signed [31:0] last_current,     last_current_next;
  logic signed [31:0] last_voltage,     last_voltage_next;
  logic signed [31:0] last_target,      last_target_next;
  logic               last_target_valid, last_target_valid_next;
  logic               have_last_sample, have_last_sample_next;
  logic               done_flag,        done_flag_next;
  // last_target takes the new table entry in the cycle after a target advance
  logic               tgt_pend,         tgt_pend_next;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic    s1_valid, s2_valid;
  gvc_s1_t s1;
  gvc_s2_t s2, s2_next;
  logic    in_take, out_free, s2_go, s1_go, s2_hazard;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign s2_go    = s2_valid && out_free;
  // Hold a sample in the read stage while the item ahead changes its target
  assign s1_go    = s1_valid && (!s2_valid || s2_go) &&
                    !((s1.op == OP_SAMPLE) && s2_valid && s2_hazard);
  assign in_stall = s1_valid && !s1_go;

  // --------------------------------------------------------------------------
  // Target table: written on input beat, read at the next pointer value every cycle
  // --------------------------------------------------------------------------
  logic              tbl_we;
  logic [31:0]       ram_q;

  assign tbl_we = in_take && (opcode == OP_LOAD) && (32'(table_index) < MAX_TARGETS);

  gvc_ram #(
    .DATA_W (32),
    .DEPTH  (MAX_TARGETS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ADDR_W'(table_index)),
    .wdata (table_value),
    .raddr (ADDR_W'(target_pointer_next)),
    .rdata (ram_q)
  );

  // --------------------------------------------------------------------------
  // Read stage: select target, form error and products
  // --------------------------------------------------------------------------
  logic signed [31:0] s1_target;
  logic signed [32:0] s1_diff;
  logic signed [31:0] s1_err;
  logic [31:0]        s1_err_mag, s1_tgt_mag, s1_scale;
  logic [32:0]        s1_diff_mag;
  logic [63:0]        s1_step_prod;

  always_comb begin
    s1_target = sweep_mode ? $signed(ram_q) : s1.ext;
    s1_diff   = $signed({s1.meas[31], s1.meas} - {s1_target[31], s1_target});
    // saturate the error to 32 bits
    if (s1_diff[32] != s1_diff[31]) begin
      s1_err = s1_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      s1_err = s1_diff[31:0];
    end
    s1_err_mag  = s1_err[31] ? (~s1_err + 32'd1) : s1_err;
    s1_diff_mag = s1_diff[32] ? (~s1_diff + 33'd1) : s1_diff;
    s1_tgt_mag  = s1_target[31] ? (~s1_target + 32'd1) : s1_target;
    s1_scale    = (s1_tgt_mag < 32'(CURRENT_SCALE_FLOOR)) ?
                  32'(CURRENT_SCALE_FLOOR) : s1_tgt_mag;
    s1_step_prod = 64'(s1_err_mag) * 64'(loop_gain);

    s2_next.op         = s1.op;
    s2_next.tbl_index  = s1.tbl_index;
    s2_next.meas       = s1.meas;
    s2_next.applied    = s1.applied;
    s2_next.now        = s1.now;
    s2_next.target     = s1_target;
    s2_next.err        = s1_err;
    s2_next.diff_mag   = s1_diff_mag;
    s2_next.step_mag   = s1_step_prod[63:24];
    s2_next.tol_scale  = 48'(current_tolerance) * 48'(s1_scale);
    s2_next.stab_scale = 48'(STABILITY_TOLERANCE) * 48'(s1_scale);
  end

  // --------------------------------------------------------------------------
  // Update stage: clamps, stability tests, hold and sweep bookkeeping
  // --------------------------------------------------------------------------
  logic               sclip, vclip, atlim, ontgt, vstab, cstab, stable_ok;
  logic [30:0]        smag;
  logic [31:0]        step;
  logic signed [32:0] req, v_max33, v_min33, clamp_hi, clamp;
  logic signed [32:0] vd, cd;
  logic [32:0]        vd_mag, cd_mag;
  logic               chg, hls_eff, hold, acc, adv, s2_load_ok;
  logic [31:0]        hs_eff;
  logic [7:0]         sc_eff, sc_new;

  always_comb begin
    // limit the step and apply the sign of the error
    sclip = s2.step_mag > 40'(max_voltage_step);
    smag  = sclip ? max_voltage_step : s2.step_mag[30:0];
    step  = s2.err[31] ? (32'd0 - {1'b0, smag}) : {1'b0, smag};

    // clamp the command: upper limit first, then lower
    req      = $signed({s2.applied[31], s2.applied} + {step[31], step});
    v_max33  = $signed({max_voltage[31], max_voltage});
    v_min33  = $signed({min_voltage[31], min_voltage});
    clamp_hi = (req < v_max33) ? req : v_max33;
    clamp    = (clamp_hi < v_min33) ? v_min33 : clamp_hi;
    vclip    = clamp != req;
    atlim    = (s2.applied == min_voltage) || (s2.applied == max_voltage);

    // on-target and stability tests
    ontgt  = {s2.diff_mag, 16'd0} <= {1'b0, s2.tol_scale};
    vd     = $signed({s2.applied[31], s2.applied} - {last_voltage[31], last_voltage});
    vd_mag = vd[32] ? (~vd + 33'd1) : vd;
    cd     = $signed({s2.meas[31], s2.meas} - {last_current[31], last_current});
    cd_mag = cd[32] ? (~cd + 33'd1) : cd;

    // a new target restarts hold and history
    chg     = !last_target_valid || (s2.target != last_target);
    hs_eff  = chg ? s2.now : hold_start;
    sc_eff  = chg ? 8'd0 : stable_counter;
    hls_eff = chg ? 1'b0 : have_last_sample;

    vstab = !hls_eff || (vd_mag <= 33'(voltage_tolerance));
    cstab = !hls_eff || ({cd_mag, 16'd0} <= {1'b0, s2.stab_scale});

    stable_ok = ontgt && vstab && cstab && !atlim && !vclip;
    if (!stable_ok) begin
      sc_new = 8'd0;
    end else if (sc_eff == 8'hFF) begin
      sc_new = 8'hFF;
    end else begin
      sc_new = sc_eff + 8'd1;
    end

    hold = {1'b0, s2.now} >= ({1'b0, hs_eff} + {1'b0, hold_duration});
    acc  = sweep_mode && !done_flag && hold && (sc_new >= required_stable_samples);
    adv  = acc && (({1'b0, target_pointer} + 5'd1) < target_count);

    s2_load_ok = (s2.op == OP_LOAD) && (32'(s2.tbl_index) < MAX_TARGETS);
    s2_hazard  = ((s2.op == OP_SAMPLE) && adv) || (s2.op == OP_LOAD) ||
                 (s2.op == OP_CLEAR);
  end

  // Next state: capture pending target, then retire the update-stage item
  always_comb begin
    target_count_next      = target_count;
    sweep_mode_next        = sweep_mode;
    target_pointer_next    = target_pointer;
    stable_counter_next    = stable_counter;
    hold_start_next        = hold_start;
    last_current_next      = last_current;
    last_voltage_next      = last_voltage;
    last_target_next       = last_target;
    last_target_valid_next = last_target_valid;
    have_last_sample_next  = have_last_sample;
    done_flag_next         = done_flag;
    tgt_pend_next          = 1'b0;

    if (tgt_pend) begin
      last_target_next = ram_q;
    end

    if (s2_go) begin
      case (s2.op)
        OP_SAMPLE: begin
          last_target_next       = s2.target;
          last_target_valid_next = 1'b1;
          last_current_next      = s2.meas;
          last_voltage_next      = s2.applied;
          have_last_sample_next  = 1'b1;
          stable_counter_next    = sc_new;
          hold_start_next        = hs_eff;
          if (adv) begin
            target_pointer_next   = target_pointer + 4'd1;
            hold_start_next       = s2.now;
            stable_counter_next   = 8'd0;
            have_last_sample_next = 1'b0;
            tgt_pend_next         = 1'b1;
          end else if (acc) begin
            done_flag_next = 1'b1;
          end
        end
        OP_LOAD: begin
          if (s2_load_ok) begin
            if (target_count < ({1'b0, s2.tbl_index} + 5'd1)) begin
              target_count_next = {1'b0, s2.tbl_index} + 5'd1;
            end
            sweep_mode_next = 1'b1;
          end
        end
        OP_CLEAR: begin
          target_count_next      = 5'd0;
          sweep_mode_next        = 1'b0;
          target_pointer_next    = 4'd0;
          stable_counter_next    = 8'd0;
          done_flag_next         = 1'b0;
          have_last_sample_next  = 1'b0;
          last_target_valid_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count      <= 5'd0;
      sweep_mode        <= 1'b0;
      target_pointer    <= 4'd0;
      stable_counter    <= 8'd0;
      hold_start        <= 32'd0;
      last_current      <= 32'sd0;
      last_voltage      <= 32'sd0;
      last_target       <= 32'sd0;
      last_target_valid <= 1'b0;
      have_last_sample  <= 1'b0;
      done_flag         <= 1'b0;
      tgt_pend          <= 1'b0;
    end else begin
      target_count      <= target_count_next;
      sweep_mode        <= sweep_mode_next;
      target_pointer    <= target_pointer_next;
      stable_counter    <= stable_counter_next;
      hold_start        <= hold_start_next;
      last_current      <= last_current_next;
      last_voltage      <= last_voltage_next;
      last_target       <= last_target_next;
      last_target_valid <= last_target_valid_next;
      have_last_sample  <= have_last_sample_next;
      done_flag         <= done_flag_next;
      tgt_pend          <= tgt_pend_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_take || (s1_valid && !s1_go);
      s2_valid  <= s1_go || (s2_valid && !s2_go);
      out_valid <= s2_go || (out_valid && out_stall);
    end
  end

  // Advance payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.op        <= opcode;
      s1.tbl_index <= table_index;
      s1.meas      <= measured_current;
      s1.applied   <= applied_voltage;
      s1.ext       <= external_target;
      s1.now       <= now_ticks;
    end
    if (s1_go) begin
      s2 <= s2_next;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s2_go) begin
      sweep_complete <= done_flag_next;
      if (s2.op == OP_SAMPLE) begin
        next_voltage     <= clamp[31:0];
        apply_voltage    <= !done_flag;
        current_error    <= s2.err;
        step_clipped     <= sclip;
        voltage_clipped  <= vclip;
        voltage_at_limit <= atlim;
        stable_count     <= sc_new;
        point_accepted   <= acc;
        active_index     <= target_pointer;
        active_target    <= s2.target;
      end else begin
        next_voltage     <= 32'sd0;
        apply_voltage    <= 1'b0;
        current_error    <= 32'sd0;
        step_clipped     <= 1'b0;
        voltage_clipped  <= 1'b0;
        voltage_at_limit <= 1'b0;
        stable_count     <= stable_counter_next;
        point_accepted   <= 1'b0;
        active_index     <= target_pointer_next;
        active_target    <= 32'sd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A pending target capture never coincides with a sample in the update stage
  assert property (@(posedge clk) disable iff (rst)
    tgt_pend |-> !(s2_valid && (s2.op == OP_SAMPLE)))
    else $error("target capture overlaps a sample update");

  // A target advance moves the pointer by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (s2_go && (s2.op == OP_SAMPLE) && adv) |=>
      (target_pointer == $past(target_pointer) + 4'd1))
    else $error("target pointer did not advance by one");

  // The pointer stays inside the loaded table
  assert property (@(posedge clk) disable iff (rst)
    (target_count != 5'd0) |-> ({1'b0, target_pointer} < target_count))
    else $error("target pointer beyond loaded table");

  // Completion is only reached in sweep mode
  assert property (@(posedge clk) disable iff (rst)
    done_flag |-> sweep_mode)
    else $error("sweep complete without sweep mode");

  // A sample never leaves the read stage while the item ahead changes its target
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1.op == OP_SAMPLE)) |-> !(s2_valid && s2_hazard))
    else $error("sample passed a target hazard");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the galvanostatic voltage controller core. A short
// table of directed beats covers reset behavior, field extremes, every
// opcode, step and window clamps, an inverted window, zero required samples
// and sweep completion. Random sweeps, steady runs and noise follow under
// several register settings. Every result beat is compared field by field
// with an in-bench predictor while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import gvc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 13;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 60;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] meas;
    logic signed [31:0] applied;
    logic signed [31:0] ext;
    logic [31:0]        now;
    logic [3:0]         idx;
    logic signed [31:0] val;
  } item_t;

  typedef struct packed {
    logic signed [31:0] next_v;
    logic               apply;
    logic signed [31:0] err;
    logic               sclip;
    logic               vclip;
    logic               atlim;
    logic [7:0]         cnt;
    logic               acc;
    logic               done;
    logic [3:0]         aidx;
    logic signed [31:0] atgt;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    item_t      stim;
    logic       typed;
    res_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_SAMPLE;
  logic signed [31:0] measured_current = '0;
  logic signed [31:0] applied_voltage = '0;
  logic signed [31:0] external_target = '0;
  logic [31:0]        now_ticks = '0;
  logic [3:0]         table_index = '0;
  logic signed [31:0] table_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] next_voltage;
  logic               apply_voltage;
  logic signed [31:0] current_error;
  logic               step_clipped;
  logic               voltage_clipped;
  logic               voltage_at_limit;
  logic [7:0]         stable_count;
  logic               point_accepted;
  logic               sweep_complete;
  logic [3:0]         active_index;
  logic signed [31:0] active_target;

  galvanostatic_voltage_controller_core dut (.*);

  // Shadow registers
  logic [31:0] gain_r = 32'd0;
  logic [30:0] vstep_r = 31'h7FFF_FFFF;
  longint      vmin_r = S32_MIN;
  longint      vmax_r = S32_MAX;
  logic [15:0] ctol_r = 16'd3277;
  logic [30:0] vtol_r = 31'd328;
  logic [7:0]  nsamp_r = 8'd5;
  logic [31:0] hold_r = 32'd30;

  // Shadow controller state
  logic signed [31:0] targets [16];
  logic [4:0]  target_cnt = '0;
  bit          sweep_on = 1'b0;
  logic [3:0]  point_ptr = '0;
  logic [7:0]  steady_cnt = '0;
  logic [31:0] hold_from = '0;
  longint      prev_meas = 0;
  longint      prev_volts = 0;
  longint      held_target = 0;
  bit          held_valid = 1'b0;
  bit          have_prev = 1'b0;
  bit          sweep_done = 1'b0;

  res_t        pending_results [$];
  row_t        dir_rows [$];
  int          written_prefix = 0;
  logic [31:0] tick = '0;
  bit          steady_flow = 1'b0;
  bit          holdoff_go = 1'b0;
  int          holdoff_left = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          points_taken = 0;
  int          sweeps_done = 0;
  int          settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > S32_MAX) return 32'sh7FFF_FFFF;
    if (v < S32_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rand_q500();
    return int'($urandom_range(0, 65536000)) - 32768000;
  endfunction

  // Work out the result of one beat and advance the shadow state
  function automatic res_t predict_control(input item_t it);
    res_t       r;
    longint     tgt, diff, err, step, req, nxt;
    bit [63:0]  scale, smag;
    logic [3:0] used;
    bit         ontgt, vstab, cstab, hold, acc;
    r = '0;
    if (it.op != OP_SAMPLE) begin
      if (it.op == OP_LOAD) begin
        targets[it.idx] = it.val;
        if (target_cnt < it.idx + 1) target_cnt = it.idx + 1;
        sweep_on = 1'b1;
      end else if (it.op == OP_CLEAR) begin
        target_cnt = '0;
        sweep_on = 1'b0;
        point_ptr = '0;
        steady_cnt = '0;
        sweep_done = 1'b0;
        have_prev = 1'b0;
        held_valid = 1'b0;
      end
      r.cnt = steady_cnt;
      r.done = sweep_done;
      r.aidx = point_ptr;
      return r;
    end

    used = point_ptr;
    tgt = sweep_on ? longint'(targets[point_ptr]) : longint'(it.ext);

    // New target: restart the hold and forget the previous sample
    if (!held_valid || tgt != held_target) begin
      hold_from = it.now;
      steady_cnt = '0;
      have_prev = 1'b0;
      held_target = tgt;
      held_valid = 1'b1;
    end

    diff = longint'(it.meas) - tgt;
    err = (diff > S32_MAX) ? S32_MAX : ((diff < S32_MIN) ? S32_MIN : diff);
    scale = abs64(tgt);
    if (scale < 64'(CURRENT_SCALE_FLOOR)) scale = 64'(CURRENT_SCALE_FLOOR);

    // Proportional step, magnitude truncated, then clamped
    smag = (abs64(err) * 64'(gain_r)) >> 24;
    r.sclip = smag > 64'(vstep_r);
    if (r.sclip) smag = 64'(vstep_r);
    step = (err < 0) ? -longint'(smag) : longint'(smag);

    // Upper clamp first, lower clamp wins on an inverted window
    req = longint'(it.applied) + step;
    nxt = (req < vmax_r) ? req : vmax_r;
    if (nxt < vmin_r) nxt = vmin_r;
    r.vclip = nxt != req;
    r.atlim = (longint'(it.applied) == vmin_r) || (longint'(it.applied) == vmax_r);

    ontgt = (abs64(diff) << 16) <= 64'(ctol_r) * scale;
    vstab = !have_prev || abs64(longint'(it.applied) - prev_volts) <= 64'(vtol_r);
    cstab = !have_prev ||
            (abs64(longint'(it.meas) - prev_meas) << 16) <= 64'(STABILITY_TOLERANCE) * scale;

    if (ontgt && vstab && cstab && !r.atlim && !r.vclip)
      steady_cnt = (steady_cnt == 8'hFF) ? 8'hFF : steady_cnt + 8'd1;
    else
      steady_cnt = '0;

    hold = 64'(it.now) >= 64'(hold_from) + 64'(hold_r);
    acc = sweep_on && !sweep_done && hold && (steady_cnt >= nsamp_r);
    r.apply = !sweep_done;
    r.cnt = steady_cnt;

    prev_meas = longint'(it.meas);
    prev_volts = longint'(it.applied);
    have_prev = 1'b1;

    // Advance to the next point or flag the sweep done
    if (acc) begin
      if (point_ptr + 1 < target_cnt) begin
        point_ptr = point_ptr + 4'd1;
        held_target = longint'(targets[point_ptr]);
        held_valid = 1'b1;
        hold_from = it.now;
        steady_cnt = '0;
        have_prev = 1'b0;
      end else begin
        sweep_done = 1'b1;
      end
    end

    r.next_v = nxt[31:0];
    r.err = err[31:0];
    r.acc = acc;
    r.done = sweep_done;
    r.aidx = used;
    r.atgt = tgt[31:0];
    return r;
  endfunction

  function automatic row_t drow(input int ph, input logic [1:0] op, input logic [31:0] meas,
                                input logic [31:0] applied, input logic [31:0] ext,
                                input logic [31:0] now, input logic [3:0] idx,
                                input logic [31:0] val, input bit typed = 1'b0,
                                input res_t want = '0);
    row_t rw;
    rw.phase = ph[1:0];
    rw.stim = item_t'{op, meas, applied, ext, now, idx, val};
    rw.typed = typed;
    rw.want = want;
    return rw;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    int    hi;
    it.op = $urandom_range(0, 3);
    it.meas = $urandom;
    it.applied = $urandom;
    it.ext = $urandom;
    it.now = $urandom;
    it.val = $urandom;
    // Keep loads within the written prefix or at its next entry, so no unwritten entry is read
    hi = (written_prefix < 16) ? written_prefix : 15;
    it.idx = (it.op == OP_LOAD) ? 4'($urandom_range(0, hi)) : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: it.applied = vmin_r[31:0];
      1: it.applied = vmax_r[31:0];
      2: it.meas = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: ;
    endcase
    return it;
  endfunction

  // Offer one beat, hold it until taken, then record its expected result
  task automatic push_item(input item_t it, input bit typed = 1'b0, input res_t want = '0);
    res_t r;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= it.op;
    measured_current <= it.meas;
    applied_voltage <= it.applied;
    external_target <= it.ext;
    now_ticks <= it.now;
    table_index <= it.idx;
    table_value <= it.val;
    do @(posedge clk); while (in_stall);
    r = predict_control(it);
    pending_results.push_back(typed ? want : r);
    if (it.op != OP_UNUSED) beats_in++;
    if (r.acc) points_taken++;
    if (r.acc && r.done) sweeps_done++;
    if (it.op == OP_LOAD && int'(it.idx) == written_prefix) written_prefix++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain the block, then write all eight registers back to back
  task automatic program_regs(input logic [31:0] gain, input logic [31:0] vstep,
                              input logic [31:0] vmin, input logic [31:0] vmax,
                              input logic [31:0] ctol, input logic [31:0] vtol,
                              input logic [31:0] nsamp, input logic [31:0] hold);
    logic [31:0] vals [8];
    vals[CFG_LOOP_GAIN] = gain;
    vals[CFG_MAX_VOLTAGE_STEP] = vstep;
    vals[CFG_MIN_VOLTAGE] = vmin;
    vals[CFG_MAX_VOLTAGE] = vmax;
    vals[CFG_CURRENT_TOL] = ctol;
    vals[CFG_VOLTAGE_TOL] = vtol;
    vals[CFG_STABLE_SAMPLES] = nsamp;
    vals[CFG_HOLD_DURATION] = hold;
    in_valid <= 1'b0;
    wait_drained();
    for (int k = 0; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      case (3'(k))
        CFG_LOOP_GAIN:        gain_r = vals[k];
        CFG_MAX_VOLTAGE_STEP: vstep_r = vals[k][30:0];
        CFG_MIN_VOLTAGE:      vmin_r = longint'($signed(vals[k]));
        CFG_MAX_VOLTAGE:      vmax_r = longint'($signed(vals[k]));
        CFG_CURRENT_TOL:      ctol_r = vals[k][15:0];
        CFG_VOLTAGE_TOL:      vtol_r = vals[k][30:0];
        CFG_STABLE_SAMPLES:   nsamp_r = vals[k][7:0];
        CFG_HOLD_DURATION:    hold_r = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Well-formed sweep: load a table, then sample near each target
  task automatic run_sweep();
    int    n, cap;
    item_t it;
    logic signed [31:0] volts;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) != 0) begin
      it = noise_item();
      it.op = OP_CLEAR;
      push_item(it);
    end
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      it.op = OP_LOAD;
      it.idx = 4'(k);
      it.val = ($urandom_range(0, 9) == 0) ? 32'($urandom) : rand_q500();
      push_item(it);
    end
    volts = rand_q500();
    cap = n * 14 + 10;
    for (int k = 0; k < cap && !sweep_done; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        push_item(noise_item());
      end else begin
        it = noise_item();
        it.op = OP_SAMPLE;
        if ($urandom_range(0, 11) == 0) volts = rand_q500();
        it.applied = volts;
        if ($urandom_range(0, 14) != 0)
          it.meas = sat32(longint'(targets[point_ptr]) +
                          longint'($urandom_range(0, 2000)) - 1000);
        tick = tick + $urandom_range(0, 3);
        it.now = tick;
        push_item(it);
      end
    end
  endtask

  // Long run on one external target, enough to saturate the stable counter
  task automatic run_steady();
    item_t it;
    logic signed [31:0] goal, volts;
    it = noise_item();
    it.op = OP_CLEAR;
    push_item(it);
    goal = rand_q500();
    volts = rand_q500();
    repeat (270) begin
      it = noise_item();
      it.op = OP_SAMPLE;
      it.ext = goal;
      it.applied = volts;
      it.meas = sat32(longint'(goal) + longint'($urandom_range(0, 400)) - 200);
      tick = tick + 1;
      it.now = tick;
      push_item(it);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_go) begin
      holdoff_go = 1'b0;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic cmp(input string fname, input longint want, input longint got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t result beat with nothing pending", $time);
      end else begin
        w = pending_results.pop_front();
        beats_out++;
        cmp("next_voltage", longint'(w.next_v), longint'(next_voltage));
        cmp("apply_voltage", longint'(w.apply), longint'(apply_voltage));
        cmp("current_error", longint'(w.err), longint'(current_error));
        cmp("step_clipped", longint'(w.sclip), longint'(step_clipped));
        cmp("voltage_clipped", longint'(w.vclip), longint'(voltage_clipped));
        cmp("voltage_at_limit", longint'(w.atlim), longint'(voltage_at_limit));
        cmp("stable_count", longint'(w.cnt), longint'(stable_count));
        cmp("point_accepted", longint'(w.acc), longint'(point_accepted));
        cmp("sweep_complete", longint'(w.done), longint'(sweep_complete));
        cmp("active_index", longint'(w.aidx), longint'(active_index));
        cmp("active_target", longint'(w.atgt), longint'(active_target));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles, %0d results pending", $time,
               quiet_cycles, pending_results.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int  cur, p, goal;
    bit  easy;
    logic [31:0] lo, hi;

    // Directed beats at reset settings
    dir_rows.push_back(drow(0, OP_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b1,
      res_t'{32'sd0, 1'b1, 32'sd0, 1'b0, 1'b0, 1'b0, 8'd1, 1'b0, 1'b0, 4'd0, 32'sd0}));
    dir_rows.push_back(drow(0, OP_UNUSED, 32'hDEAD_BEEF, 5, 6, 7, 4'hF, 32'hFFFF_FFFF, 1'b1,
      res_t'{32'sd0, 1'b0, 32'sd0, 1'b0, 1'b0, 1'b0, 8'd1, 1'b0, 1'b0, 4'd0, 32'sd0}));
    dir_rows.push_back(drow(0, OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0));
    dir_rows.push_back(drow(0, OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 2, 0, 0));
    dir_rows.push_back(drow(0, OP_CLEAR, 0, 0, 0, 3, 0, 0, 1'b1, '0));
    // Unit gain, narrow window: a three-point sweep to completion
    dir_rows.push_back(drow(1, OP_LOAD, 0, 0, 0, 0, 4'd0, ONE, 1'b1, '0));
    dir_rows.push_back(drow(1, OP_LOAD, 0, 0, 0, 0, 4'd1, -2 * ONE));
    dir_rows.push_back(drow(1, OP_LOAD, 0, 0, 0, 0, 4'd2, 32'h7FFF_FFFF));
    dir_rows.push_back(drow(1, OP_SAMPLE, ONE, ONE, 0, 100, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, ONE, ONE, 0, 101, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, ONE, ONE, 0, 103, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, -2 * ONE, ONE, 0, 104, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, -2 * ONE, ONE, 0, 106, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, 32'h7FFF_FFFF, ONE, 0, 110, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, 32'h7FFF_FFFF, ONE, 0, 120, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, 0, ONE, 0, 121, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, 0, -8 * ONE, 0, 122, 0, 0));
    dir_rows.push_back(drow(1, OP_SAMPLE, 0, 10 * ONE, 0, 123, 0, 0));
    // Extreme gain, step, window and tolerances
    dir_rows.push_back(drow(2, OP_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1, '0));
    dir_rows.push_back(drow(2, OP_SAMPLE, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0));
    dir_rows.push_back(drow(2, OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            5, 0, 0));
    // Inverted window, zero samples and zero hold
    dir_rows.push_back(drow(3, OP_SAMPLE, 3, 0, 7, 7, 0, 0));
    dir_rows.push_back(drow(3, OP_LOAD, 0, 0, 0, 0, 4'd0, 5 * ONE));
    dir_rows.push_back(drow(3, OP_SAMPLE, 0, 0, 0, 9, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 0;
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].phase) != cur) begin
        cur = dir_rows[i].phase;
        case (cur)
          1: program_regs(32'h0100_0000, 5 * ONE, -10 * ONE, 10 * ONE, 3277, 328, 2, 3);
          2: program_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          65535, 32'h7FFF_FFFF, 255, 32'hFFFF_FFFF);
          default: program_regs(0, 1, 32'h7FFF_FFFE, 32'h8000_0001, 0, 0, 0, 0);
        endcase
      end
      push_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under fresh settings
    goal = beats_in + RANDOM_ITEMS;
    p = 0;
    while (beats_in < goal) begin
      easy = (p <= 3) || ($urandom_range(0, 3) != 0);
      if (easy) begin
        program_regs($urandom_range(0, 32'h0200_0000), $urandom_range(1, 32'h0040_0000),
                     -int'($urandom_range(600, 2000)) * 65536,
                     int'($urandom_range(600, 2000)) * 65536,
                     $urandom_range(1000, 8000), $urandom_range(0, 65536),
                     $urandom_range(0, 6), $urandom_range(0, 12));
      end else begin
        lo = $urandom;
        hi = $urandom;
        if (lo == 32'h7FFF_FFFF) lo = 32'h7FFF_FFFE;
        if (hi == 32'h8000_0000) hi = 32'h8000_0001;
        program_regs($urandom, $urandom_range(1, 32'h7FFF_FFFF), lo, hi,
                     $urandom_range(0, 65535), $urandom & 32'h7FFF_FFFF,
                     $urandom_range(1, 255), $urandom);
      end
      tick = (p == 4) ? 32'hFFFF_FFE0 : $urandom_range(0, 32'h0010_0000);
      steady_flow = (p == 2);
      if (p == 1) run_steady();
      for (int s = 0; s < 4; s++) begin
        if (p == 3 && s == 1) holdoff_go = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(5, 20)) push_item(noise_item());
        end else begin
          run_sweep();
        end
      end
      p++;
    end

    in_valid <= 1'b0;
    wait_drained();
    $display("covered %0d input beats, %0d result beats, %0d register settings",
             beats_in, beats_out, settings_used);
    $display("%0d sweep points accepted, %0d sweeps completed, %0d mismatches",
             points_taken, sweeps_done, errors);
    if (errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
